// ===== hw/rtl/asri_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC serial register interface package
// Shared constants, register select codes and write port types.
// ----------------------------------------------------------------------------
`default_nettype none

package asri_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int SYNC_BYTES   = 4;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [2:0] SEL_COMM   = 3'd0;
  localparam logic [2:0] SEL_SETUP  = 3'd1;
  localparam logic [2:0] SEL_FILT_H = 3'd2;
  localparam logic [2:0] SEL_DATA   = 3'd3;
  localparam logic [2:0] SEL_TEST   = 3'd4;
  localparam logic [2:0] SEL_FILT_L = 3'd5;
  localparam logic [2:0] SEL_ZERO   = 3'd6;
  localparam logic [2:0] SEL_FULL   = 3'd7;

  localparam int CMD_INVALID_BIT = 7;
  localparam int CMD_READ_BIT    = 3;

  localparam logic [7:0] ALL_ONES   = 8'hFF;
  localparam logic [2:0] ONES_MAX   = 3'd7;
  localparam logic [2:0] SYNC_COUNT = 3'(SYNC_BYTES);

  localparam logic [1:0] WIDE_BYTES   = 2'd3;
  localparam logic [1:0] NARROW_BYTES = 2'd1;

  localparam logic OP_HOST_BYTE = 1'b0;
  localparam logic OP_SAMPLE    = 1'b1;

  typedef struct packed {
    logic        en;
    logic [2:0]  sel;
    logic [1:0]  ch;
    logic [23:0] value;
  } reg_write_t;

  typedef struct packed {
    logic        en;
    logic [1:0]  ch;
    logic [23:0] value;
  } sample_write_t;

  function automatic logic chan_ok(input logic [1:0] ch);
    return {1'b0, ch} < 3'(NUM_CHANNELS);
  endfunction

  function automatic logic is_wide(input logic [2:0] sel);
    return (sel == SEL_DATA) || (sel == SEL_ZERO) || (sel == SEL_FULL);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/adc_serial_register_interface_core.sv =====
// ----------------------------------------------------------------------------
// ADC serial register interface core
// Device side of the byte-serial register port of a sigma-delta ADC.
//
// The slave channel carries one item per host byte (tuser = 0) or per new
// conversion sample (tuser = 1). Host bytes run the command / data phase
// machine: a command byte selects register, direction and channel, data bytes
// follow MSB first. The master channel returns exactly one item per accepted
// input item: reply byte, not-ready flag, write report, resync flag and phase.
// The result is registered and is valid in the cycle after acceptance. Throughput is one
// item per cycle while the receiver does not stall, set by the single result register;
// the phase machine and register file update in the accept cycle.
// While the receiver stalls, the result register holds and s_tready drops
// only when it is full and not being drained.
// Reset returns the interface to the command phase, clears the interface state and
// the register file and sets not-ready.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_serial_register_interface_core import asri_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: host_byte[7:0], sample_channel[9:8], sample_value[33:10], zero pad
  input  wire logic [39:0] s_tdata,
  // s_tuser: op[0]
  input  wire logic        s_tuser,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // m_tdata: reply_byte[7:0], not_ready[8], write_done[9], written_register[12:10],
  //          written_channel[14:13], written_value[38:15], resync_done[39],
  //          awaiting_command[40], zero pad
  output logic [47:0]      m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready
);

  logic        accept;
  logic [7:0]  host_byte;
  logic [1:0]  sample_channel;
  logic [23:0] sample_value;

  logic        in_command_phase, in_command_phase_next;
  logic [2:0]  target_select, target_select_next;
  logic        target_is_read, target_is_read_next;
  logic [1:0]  target_channel, target_channel_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic [23:0] shift_word, shift_word_next;
  logic [6:0]  last_command, last_command_next;
  logic        ready_flag_n, ready_flag_n_next;
  logic [2:0]  ones_byte_count, ones_byte_count_next;

  logic [7:0]  reply;
  logic        wdone;
  logic [23:0] wval;
  logic        rsync;
  logic [23:0] rd_value;
  logic [23:0] cmd_value;
  logic [23:0] data_word;
  logic [1:0]  bytes_dec;

  reg_write_t    wr;
  sample_write_t smp;

  assign host_byte      = s_tdata[7:0];
  assign sample_channel = s_tdata[9:8];
  assign sample_value   = s_tdata[33:10];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign cmd_value = (host_byte[6:4] == SEL_COMM) ?
                     {16'd0, ready_flag_n, host_byte[6:0]} : rd_value;
  assign data_word = {shift_word[15:0], host_byte};
  assign bytes_dec = (bytes_left != 2'd0) ? bytes_left - 2'd1 : 2'd0;

  always_comb begin
    in_command_phase_next = in_command_phase;
    target_select_next    = target_select;
    target_is_read_next   = target_is_read;
    target_channel_next   = target_channel;
    bytes_left_next       = bytes_left;
    shift_word_next       = shift_word;
    last_command_next     = last_command;
    ready_flag_n_next     = ready_flag_n;
    ones_byte_count_next  = ones_byte_count;
    reply                 = 8'd0;
    wdone                 = 1'b0;
    wval                  = 24'd0;
    rsync                 = 1'b0;
    wr                    = '0;
    smp                   = '0;

    if (s_tuser == OP_SAMPLE) begin
      smp.en    = 1'b1;
      smp.ch    = sample_channel;
      smp.value = sample_value;
      if (chan_ok(sample_channel)) ready_flag_n_next = 1'b0;
    end else begin
      if (host_byte == ALL_ONES) begin
        if (ones_byte_count < ONES_MAX) ones_byte_count_next = ones_byte_count + 3'd1;
      end else begin
        ones_byte_count_next = 3'd0;
      end

      if (ones_byte_count_next >= SYNC_COUNT) begin
        in_command_phase_next = 1'b1;
        target_select_next    = 3'd0;
        target_is_read_next   = 1'b0;
        target_channel_next   = 2'd0;
        bytes_left_next       = 2'd0;
        shift_word_next       = 24'd0;
        ones_byte_count_next  = 3'd0;
        rsync                 = 1'b1;
      end else if (in_command_phase) begin
        if (!host_byte[CMD_INVALID_BIT]) begin
          last_command_next     = host_byte[6:0];
          target_select_next    = host_byte[6:4];
          target_is_read_next   = host_byte[CMD_READ_BIT];
          target_channel_next   = host_byte[1:0];
          in_command_phase_next = 1'b0;
          if (is_wide(host_byte[6:4])) begin
            bytes_left_next = WIDE_BYTES;
            shift_word_next = host_byte[CMD_READ_BIT] ? cmd_value : 24'd0;
          end else begin
            bytes_left_next = NARROW_BYTES;
            shift_word_next = host_byte[CMD_READ_BIT] ? {cmd_value[7:0], 16'd0} : 24'd0;
          end
        end
      end else begin
        if (target_is_read) begin
          reply           = shift_word[23:16];
          shift_word_next = {shift_word[15:0], 8'd0};
        end else begin
          shift_word_next = data_word;
        end
        bytes_left_next = bytes_dec;
        if (bytes_dec == 2'd0) begin
          if (target_is_read) begin
            if (target_select == SEL_DATA) ready_flag_n_next = 1'b1;
          end else if (target_select != SEL_DATA) begin
            wr.en    = 1'b1;
            wr.sel   = target_select;
            wr.ch    = target_channel;
            wr.value = data_word;
            wdone    = 1'b1;
            wval     = data_word;
            if (target_select == SEL_COMM) last_command_next = data_word[6:0];
          end
          in_command_phase_next = 1'b1;
          shift_word_next       = 24'd0;
        end
      end
    end

    if (!accept) begin
      wr.en  = 1'b0;
      smp.en = 1'b0;
    end
  end

  asri_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .smp      (smp),
    .rd_sel   (host_byte[6:4]),
    .rd_ch    (host_byte[1:0]),
    .rd_value (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_command_phase <= 1'b1;
      target_select    <= 3'd0;
      target_is_read   <= 1'b0;
      target_channel   <= 2'd0;
      bytes_left       <= 2'd0;
      shift_word       <= 24'd0;
      last_command     <= 7'd0;
      ready_flag_n     <= 1'b1;
      ones_byte_count  <= 3'd0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept) begin
        in_command_phase <= in_command_phase_next;
        target_select    <= target_select_next;
        target_is_read   <= target_is_read_next;
        target_channel   <= target_channel_next;
        bytes_left       <= bytes_left_next;
        shift_word       <= shift_word_next;
        last_command     <= last_command_next;
        ready_flag_n     <= ready_flag_n_next;
        ones_byte_count  <= ones_byte_count_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0, in_command_phase_next, rsync, wval,
                  wdone ? target_channel : 2'd0,
                  wdone ? target_select : 3'd0,
                  wdone, ready_flag_n_next, reply};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/asri_regfile.sv =====
// ----------------------------------------------------------------------------
// ADC serial register interface register file
// Setup, filter, test, calibration and sample registers with a read mux.
// ----------------------------------------------------------------------------
`default_nettype none

module asri_regfile import asri_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire reg_write_t    wr,
  input  wire sample_write_t smp,
  input  wire logic [2:0]    rd_sel,
  input  wire logic [1:0]    rd_ch,
  output logic [23:0]        rd_value
);

  logic [7:0]  setup_reg;
  logic [7:0]  filter_high_reg;
  logic [7:0]  filter_low_reg;
  logic [7:0]  test_reg;
  logic [23:0] zero_cal [NUM_CHANNELS];
  logic [23:0] full_cal [NUM_CHANNELS];
  logic [23:0] latest_sample [NUM_CHANNELS];

  logic [CH_IDX_W-1:0] wr_idx;
  logic [CH_IDX_W-1:0] smp_idx;
  logic [CH_IDX_W-1:0] rd_idx;

  assign wr_idx  = wr.ch[CH_IDX_W-1:0];
  assign smp_idx = smp.ch[CH_IDX_W-1:0];
  assign rd_idx  = rd_ch[CH_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_reg       <= '0;
      filter_high_reg <= '0;
      filter_low_reg  <= '0;
      test_reg        <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        zero_cal[i]      <= '0;
        full_cal[i]      <= '0;
        latest_sample[i] <= '0;
      end
    end else begin
      if (wr.en) begin
        case (wr.sel)
          SEL_SETUP:  setup_reg       <= wr.value[7:0];
          SEL_FILT_H: filter_high_reg <= wr.value[7:0];
          SEL_TEST:   test_reg        <= wr.value[7:0];
          SEL_FILT_L: filter_low_reg  <= wr.value[7:0];
          SEL_ZERO: begin
            if (chan_ok(wr.ch)) zero_cal[wr_idx] <= wr.value;
          end
          SEL_FULL: begin
            if (chan_ok(wr.ch)) full_cal[wr_idx] <= wr.value;
          end
          default: ;
        endcase
      end
      if (smp.en && chan_ok(smp.ch)) begin
        latest_sample[smp_idx] <= smp.value;
      end
    end
  end

  always_comb begin
    case (rd_sel)
      SEL_SETUP:  rd_value = {16'd0, setup_reg};
      SEL_FILT_H: rd_value = {16'd0, filter_high_reg};
      SEL_DATA:   rd_value = chan_ok(rd_ch) ? latest_sample[rd_idx] : 24'd0;
      SEL_TEST:   rd_value = {16'd0, test_reg};
      SEL_FILT_L: rd_value = {16'd0, filter_low_reg};
      SEL_ZERO:   rd_value = chan_ok(rd_ch) ? zero_cal[rd_idx] : 24'd0;
      SEL_FULL:   rd_value = chan_ok(rd_ch) ? full_cal[rd_idx] : 24'd0;
      default:    rd_value = 24'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/adc_serial_register_interface_core_test.sv =====
// ----------------------------------------------------------------------------
// ADC serial register interface core testbench
// Drives host bytes and conversion samples into the slave stream with bursty
// timing and a stalling receiver. A scoreboard predicts each reply item and
// compares every returned item field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_serial_register_interface_core_test import asri_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        awaiting;
    logic        resync;
    logic [23:0] wvalue;
    logic [1:0]  wch;
    logic [2:0]  wreg;
    logic        wdone;
    logic        nrdy;
    logic [7:0]  reply;
  } port_reply_t;

  class serial_scoreboard;
    port_reply_t expected_replies[$];
    int          failures;

    bit          cmd_phase;
    logic [2:0]  tsel;
    bit          tread;
    logic [1:0]  tch;
    logic [1:0]  left;
    logic [23:0] shift;
    logic [6:0]  last_cmd;
    logic [7:0]  setup_r;
    logic [7:0]  filt_h_r;
    logic [7:0]  filt_l_r;
    logic [7:0]  test_r;
    logic [23:0] zero_r[4];
    logic [23:0] full_r[4];
    logic [23:0] sample_r[4];
    bit          nrdy;
    logic [2:0]  ones;

    function new();
      failures = 0;
      clear_interface();
      last_cmd = '0;
      setup_r  = '0;
      filt_h_r = '0;
      filt_l_r = '0;
      test_r   = '0;
      for (int i = 0; i < 4; i++) begin
        zero_r[i]   = '0;
        full_r[i]   = '0;
        sample_r[i] = '0;
      end
      nrdy = 1'b1;
    endfunction

    function void clear_interface();
      cmd_phase = 1'b1;
      tsel      = '0;
      tread     = 1'b0;
      tch       = '0;
      left      = '0;
      shift     = '0;
      ones      = '0;
    endfunction

    function logic [23:0] reg_value(logic [2:0] sel, logic [1:0] ch);
      bit ok;
      ok = ch < NUM_CHANNELS;
      case (sel)
        SEL_COMM:   return {16'h0, nrdy, last_cmd};
        SEL_SETUP:  return {16'h0, setup_r};
        SEL_FILT_H: return {16'h0, filt_h_r};
        SEL_DATA:   return ok ? sample_r[ch] : 24'h0;
        SEL_TEST:   return {16'h0, test_r};
        SEL_FILT_L: return {16'h0, filt_l_r};
        SEL_ZERO:   return ok ? zero_r[ch] : 24'h0;
        default:    return ok ? full_r[ch] : 24'h0;
      endcase
    endfunction

    function void note_item(logic op, logic [7:0] b, logic [1:0] ch, logic [23:0] v);
      port_reply_t r;
      logic [23:0] rv;
      r = '0;
      if (op == OP_SAMPLE) begin
        if (ch < NUM_CHANNELS) begin
          sample_r[ch] = v;
          nrdy = 1'b0;
        end
      end else begin
        if (b == ALL_ONES) begin
          if (ones < ONES_MAX) ones++;
        end else begin
          ones = '0;
        end
        if (ones >= SYNC_COUNT) begin
          clear_interface();
          r.resync = 1'b1;
        end else if (cmd_phase) begin
          if (!b[CMD_INVALID_BIT]) begin
            last_cmd = b[6:0];
            tsel     = b[6:4];
            tread    = b[CMD_READ_BIT];
            tch      = b[1:0];
            rv       = reg_value(tsel, tch);
            if (tsel == SEL_DATA || tsel == SEL_ZERO || tsel == SEL_FULL) begin
              left  = WIDE_BYTES;
              shift = tread ? rv : 24'h0;
            end else begin
              left  = NARROW_BYTES;
              shift = tread ? {rv[7:0], 16'h0} : 24'h0;
            end
            cmd_phase = 1'b0;
          end
        end else begin
          if (tread) begin
            r.reply = shift[23:16];
            shift   = {shift[15:0], 8'h00};
          end else begin
            shift = {shift[15:0], b};
          end
          if (left != 0) left--;
          if (left == 0) begin
            if (tread) begin
              if (tsel == SEL_DATA) nrdy = 1'b1;
            end else if (tsel != SEL_DATA) begin
              case (tsel)
                SEL_COMM:   last_cmd = shift[6:0];
                SEL_SETUP:  setup_r  = shift[7:0];
                SEL_FILT_H: filt_h_r = shift[7:0];
                SEL_TEST:   test_r   = shift[7:0];
                SEL_FILT_L: filt_l_r = shift[7:0];
                SEL_ZERO:   if (tch < NUM_CHANNELS) zero_r[tch] = shift;
                SEL_FULL:   if (tch < NUM_CHANNELS) full_r[tch] = shift;
                default: ;
              endcase
              r.wdone  = 1'b1;
              r.wreg   = tsel;
              r.wch    = tch;
              r.wvalue = shift;
            end
            cmd_phase = 1'b1;
            shift     = '0;
          end
        end
      end
      r.nrdy     = nrdy;
      r.awaiting = cmd_phase;
      expected_replies.push_back(r);
    endfunction

    function void check_result(logic [47:0] data);
      port_reply_t got;
      port_reply_t want;
      got = data[40:0];
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected reply item %h at %0t", data, $realtime);
      end else begin
        want = expected_replies.pop_front();
        if (got != want) begin
          failures++;
          if (failures <= 10) begin
            $write("mismatch at %0t: reply %h/%h nrdy %b/%b wdone %b/%b reg %0d/%0d ",
                   $realtime, want.reply, got.reply, want.nrdy, got.nrdy,
                   want.wdone, got.wdone, want.wreg, got.wreg);
            $display("ch %0d/%0d value %h/%h resync %b/%b awaiting %b/%b (exp/got)",
                     want.wch, got.wch, want.wvalue, got.wvalue,
                     want.resync, got.resync, want.awaiting, got.awaiting);
          end
        end
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic [39:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  serial_scoreboard board;
  int burst_left = 0;
  int rx_left    = 0;
  int items_sent = 0;

  adc_serial_register_interface_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        m_tready <= 1'b1;
        rx_left = $urandom_range(50, 200);
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
        rx_left = $urandom_range(1, 6);
      end
    end else begin
      rx_left--;
    end
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  task automatic send_item(input logic op, input logic [7:0] b, input logic [1:0] ch,
                           input logic [23:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, v, ch, b};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    board.note_item(op, b, ch, v);
    @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_host(input logic [7:0] b);
    send_item(OP_HOST_BYTE, b, 2'($urandom), 24'($urandom));
  endtask

  task automatic send_sample(input logic [1:0] ch, input logic [23:0] v);
    send_item(OP_SAMPLE, 8'($urandom), ch, v);
  endtask

  function automatic logic [7:0] data_byte();
    return ($urandom_range(0, 7) == 0) ? ALL_ONES : 8'($urandom);
  endfunction

  initial begin
    int          kind;
    int          nbytes;
    logic [2:0]  sel;
    logic [7:0]  cmd;
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_host({1'b0, SEL_COMM, 4'b1000});
    send_host(8'h00);
    send_host({1'b0, SEL_SETUP, 4'b0000});
    send_host(8'hA5);
    send_host({1'b0, SEL_ZERO, 4'b0011});
    send_host(8'h12);
    send_host(8'h34);
    send_host(8'h56);
    send_host(8'h80);
    send_sample(2'd1, 24'hFFFFFF);
    send_host({1'b0, SEL_DATA, 4'b1001});
    send_host(ALL_ONES);
    send_host(ALL_ONES);
    send_host(ALL_ONES);
    send_host(ALL_ONES);
    send_host({1'b0, SEL_COMM, 4'b0100});
    send_host(8'h7F);
    send_host({1'b0, SEL_COMM, 4'b1100});
    send_host(8'h00);
    send_host({1'b0, SEL_FILT_L, 4'b0000});
    send_host(8'h00);
    send_sample(2'd0, 24'h000000);
    send_host({1'b0, SEL_DATA, 4'b0000});
    send_host(8'hAA);
    send_host(8'hAA);
    send_host(8'hAA);

    while (items_sent < 1850) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        sel = 3'($urandom);
        cmd = {1'b0, sel, 1'($urandom), 1'($urandom), 2'($urandom)};
        nbytes = (sel == SEL_DATA || sel == SEL_ZERO || sel == SEL_FULL) ? 3 : 1;
        send_host(cmd);
        for (int i = 0; i < nbytes; i++) begin
          if ($urandom_range(0, 15) == 0) send_sample(2'($urandom), 24'($urandom));
          send_host(data_byte());
        end
      end else if (kind < 88) begin
        send_sample(2'($urandom), 24'($urandom));
      end else if (kind < 94) begin
        send_host(8'($urandom));
      end else if (kind < 97) begin
        nbytes = $urandom_range(4, 7);
        repeat (nbytes) send_host(ALL_ONES);
      end else begin
        sel = 3'($urandom);
        send_host({1'b0, sel, 1'($urandom), 1'($urandom), 2'($urandom)});
        nbytes = $urandom_range(0, 2);
        repeat (nbytes) send_host(data_byte());
      end
    end
    s_tvalid <= 1'b0;

    while (board.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== adc_serial_register_interface_core.f =====
hw/rtl/asri_pkg.sv
hw/rtl/asri_regfile.sv
hw/rtl/adc_serial_register_interface_core.sv
tb/adc_serial_register_interface_core_test.sv
